// ----- hdl/dftd_pkg.sv -----
package dftd_pkg;

  localparam int POINTS_DEF  = 64;
  localparam int SMP_W       = 16;
  localparam int TW_W        = 16;
  localparam int PROD_W      = 32;
  localparam int BIN_W       = 23;
  localparam int IDX_W       = 6;
  localparam int ACC_W       = 39;
  localparam int FRAC_W      = 15;
  localparam int RND_HALF    = 16384;
  localparam int OUT_MAX     = 4194303;
  localparam int OUT_MIN     = -4194304;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_MAC,
    ST_DRAIN,
    ST_FIN
  } dftd_state_e;

  typedef struct packed {
    logic issue;
    logic clear;
  } mac_ctrl_t;

endpackage

// ----- hdl/dftd_sample_mem.sv -----
module dftd_sample_mem import dftd_pkg::*; #(
  parameter int POINTS = POINTS_DEF,
  localparam int AW = $clog2(POINTS)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [2*SMP_W-1:0]   wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [2*SMP_W-1:0]   rdata_o
);

  logic [2*SMP_W-1:0] mem [POINTS];
  logic [2*SMP_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/dftd_twiddle_rom.sv -----
module dftd_twiddle_rom import dftd_pkg::*; #(
  parameter int POINTS = POINTS_DEF,
  localparam int AW = $clog2(POINTS)
) (
  input  logic                    clk_i,
  input  logic [AW-1:0]           idx_i,
  output logic signed [TW_W-1:0]  tw_cos_o,
  output logic signed [TW_W-1:0]  tw_nsin_o
);

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned SinDiv [8] = '{6, 20, 42, 72, 110, 156, 210, 272};
  localparam longint unsigned CosDiv [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

  function automatic logic [TW_W-1:0] q30_to_q15(input longint v);
    longint r;
    if (v < 0) begin
      return '0;
    end
    r = (v + 64'sd16384) >>> 15;
    if (r > 64'sd32767) begin
      r = 64'sd32767;
    end
    return TW_W'(r);
  endfunction

  // truncated Maclaurin series, eight correction terms, Q30
  function automatic logic [2*TW_W-1:0] trig_q15(input longint unsigned theta);
    longint unsigned ts;
    longint unsigned tc;
    longint s;
    longint c;
    ts = theta;
    tc = 64'd1 << 30;
    s  = longint'(theta);
    c  = longint'(64'd1 << 30);
    for (int i = 0; i < 8; i++) begin
      ts = ((((ts * theta) >> 30) * theta) >> 30) / SinDiv[i];
      tc = ((((tc * theta) >> 30) * theta) >> 30) / CosDiv[i];
      if (i % 2 == 0) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
    end
    return {q30_to_q15(c), q30_to_q15(s)};
  endfunction

  // quadrant unfold, returns {cos, -sin}
  function automatic logic [2*TW_W-1:0] tw_pack(input int unsigned quad,
                                                 input logic [TW_W-1:0] c,
                                                 input logic [TW_W-1:0] s);
    logic [TW_W-1:0] co;
    logic [TW_W-1:0] si;
    case (quad)
      0: begin
        co = c;
        si = s;
      end
      1: begin
        co = -s;
        si = c;
      end
      2: begin
        co = -c;
        si = -s;
      end
      default: begin
        co = s;
        si = -c;
      end
    endcase
    return {co, TW_W'(-si)};
  endfunction

  logic signed [TW_W-1:0] rom_cos  [POINTS];
  logic signed [TW_W-1:0] rom_nsin [POINTS];

  for (genvar m = 0; m < POINTS; m++) begin : g_tw
    localparam int unsigned Quad = (4 * m) / POINTS;
    localparam int unsigned Rem  = (4 * m) % POINTS;
    localparam longint unsigned Theta = (HalfPiQ30 * longint'(Rem)) / POINTS;
    localparam logic [2*TW_W-1:0] Cs  = trig_q15(Theta);
    localparam logic [2*TW_W-1:0] Ent = tw_pack(Quad, Cs[2*TW_W-1:TW_W], Cs[TW_W-1:0]);
    assign rom_cos[m]  = signed'(Ent[2*TW_W-1:TW_W]);
    assign rom_nsin[m] = signed'(Ent[TW_W-1:0]);
  end

  logic signed [TW_W-1:0] cos_q;
  logic signed [TW_W-1:0] nsin_q;

  always_ff @(posedge clk_i) begin
    cos_q  <= rom_cos[idx_i];
    nsin_q <= rom_nsin[idx_i];
  end

  assign tw_cos_o  = cos_q;
  assign tw_nsin_o = nsin_q;

endmodule

// ----- hdl/dftd_mac.sv -----
module dftd_mac import dftd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mac_ctrl_t               ctrl_i,
  input  logic [2*SMP_W-1:0]      smp_i,
  input  logic signed [TW_W-1:0]  tw_cos_i,
  input  logic signed [TW_W-1:0]  tw_nsin_i,
  output logic                    busy_o,
  output logic signed [BIN_W-1:0] res_real_o,
  output logic signed [BIN_W-1:0] res_imag_o
);

  logic v1_q, v2_q;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [ACC_W-1:0]  acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic signed [SMP_W-1:0]  xr, xi;

  assign xr = signed'(smp_i[SMP_W-1:0]);
  assign xi = signed'(smp_i[2*SMP_W-1:SMP_W]);

  // v1: sample and twiddle words are out of the memory and ROM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= ctrl_i.issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p_rr_q <= xr * tw_cos_i;
      p_ii_q <= xi * tw_nsin_i;
      p_ri_q <= xr * tw_nsin_i;
      p_ir_q <= xi * tw_cos_i;
    end
  end

  always_comb begin
    acc_re_d = acc_re_q;
    acc_im_d = acc_im_q;
    if (ctrl_i.clear) begin
      acc_re_d = '0;
      acc_im_d = '0;
    end else if (v2_q) begin
      acc_re_d = acc_re_q + ACC_W'(p_rr_q) - ACC_W'(p_ii_q);
      acc_im_d = acc_im_q + ACC_W'(p_ri_q) + ACC_W'(p_ir_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else begin
      acc_re_q <= acc_re_d;
      acc_im_q <= acc_im_d;
    end
  end

  // round half up: floor((acc + 2^14) / 2^15), then clamp
  function automatic logic signed [BIN_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] v;
    logic signed [ACC_W-1:0] sh;
    v  = acc + ACC_W'(RND_HALF);
    sh = v >>> FRAC_W;
    if (sh > ACC_W'(OUT_MAX)) begin
      sh = ACC_W'(OUT_MAX);
    end else if (sh < ACC_W'(OUT_MIN)) begin
      sh = ACC_W'(OUT_MIN);
    end
    return BIN_W'(sh);
  endfunction

  assign busy_o     = v1_q | v2_q;
  assign res_real_o = round_sat(acc_re_q);
  assign res_imag_o = round_sat(acc_im_q);

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.clear |-> !v1_q && !v2_q && !ctrl_i.issue)
    else $error("accumulator cleared with products in flight");

  a_pipe_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q))
    else $error("product stage valid without a read stage");

  a_issue_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.issue |=> v1_q)
    else $error("issued read lost");

endmodule

// ----- hdl/direct_dft_engine_unit.sv -----
// channel | valid      | ready      | word
// --------+------------+------------+-------------------------------------------------
// in      | in_valid_i | in_ready_o | in_real_i, in_imag_i
// bin     | bin_valid_o| bin_ready_i| bin_real_o, bin_imag_o, bin_number_o, final_bin_o
//
// Each accepted sample is stored; the frame's last sample starts the transform. Each bin
// reads every sample once from the sample memory (one write port, one read port) into one
// shared complex MAC, waits in a drain state until the MAC's v1 and v2 stages are empty,
// and is then handed over to the output register.
// Reset clears the sequencer, counters, accumulators and the bin valid; memory is not cleared.
// A stalled bin word holds the next bin in the accumulators; input waits until the last
// bin is in the output register.
module direct_dft_engine_unit import dftd_pkg::*; #(
  parameter int POINTS = POINTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [SMP_W-1:0]  in_real_i,
  input  logic signed [SMP_W-1:0]  in_imag_i,
  output logic                     bin_valid_o,
  input  logic                     bin_ready_i,
  output logic signed [BIN_W-1:0]  bin_real_o,
  output logic signed [BIN_W-1:0]  bin_imag_o,
  output logic [IDX_W-1:0]         bin_number_o,
  output logic                     final_bin_o
);

  localparam int AW = $clog2(POINTS);
  localparam logic [AW-1:0] LastIdx = AW'(POINTS - 1);

  dftd_state_e state_q, state_d;
  logic [AW-1:0] ld_cnt_q, ld_cnt_d;
  logic [AW-1:0] n_q, n_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] m_q, m_d;
  logic [AW:0]   m_sum;

  logic in_acc, out_load;
  logic last_ld, last_n, last_k;
  mac_ctrl_t mac_ctrl;
  logic mac_busy;

  logic [2*SMP_W-1:0]     smp_rd;
  logic signed [TW_W-1:0] tw_cos, tw_nsin;
  logic signed [BIN_W-1:0] res_real, res_imag;

  logic bin_valid_q, bin_valid_d;
  logic signed [BIN_W-1:0] bin_real_q, bin_imag_q;
  logic [IDX_W-1:0] bin_num_q;
  logic final_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign last_ld = (ld_cnt_q == LastIdx);
  assign last_n  = (n_q == LastIdx);
  assign last_k  = (k_q == LastIdx);

  // twiddle index steps by k, kept below POINTS
  assign m_sum = {1'b0, m_q} + {1'b0, k_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && last_ld) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC: begin
        if (last_n) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = last_k ? ST_LOAD : ST_MAC;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    mac_ctrl.issue = 1'b0;
    mac_ctrl.clear = 1'b0;
    out_load       = 1'b0;
    case (state_q)
      ST_LOAD:  in_ready_o = 1'b1;
      ST_MAC:   mac_ctrl.issue = 1'b1;
      ST_DRAIN: ;
      ST_FIN: begin
        out_load       = !bin_valid_q || bin_ready_i;
        mac_ctrl.clear = out_load;
      end
      default: ;
    endcase
  end

  always_comb begin
    ld_cnt_d = ld_cnt_q;
    n_d      = n_q;
    k_d      = k_q;
    m_d      = m_q;
    if (in_acc) begin
      ld_cnt_d = last_ld ? '0 : ld_cnt_q + 1'b1;
    end
    if (mac_ctrl.issue) begin
      n_d = last_n ? '0 : n_q + 1'b1;
      m_d = (m_sum >= (AW+1)'(POINTS)) ? AW'(m_sum - (AW+1)'(POINTS)) : AW'(m_sum);
    end
    if (out_load) begin
      k_d = last_k ? '0 : k_q + 1'b1;
      n_d = '0;
      m_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      ld_cnt_q <= '0;
      n_q      <= '0;
      k_q      <= '0;
      m_q      <= '0;
    end else begin
      state_q  <= state_d;
      ld_cnt_q <= ld_cnt_d;
      n_q      <= n_d;
      k_q      <= k_d;
      m_q      <= m_d;
    end
  end

  dftd_sample_mem #(.POINTS(POINTS)) u_mem (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (ld_cnt_q),
    .wdata_i ({in_imag_i, in_real_i}),
    .re_i    (mac_ctrl.issue),
    .raddr_i (n_q),
    .rdata_o (smp_rd)
  );

  dftd_twiddle_rom #(.POINTS(POINTS)) u_rom (
    .clk_i     (clk_i),
    .idx_i     (m_q),
    .tw_cos_o  (tw_cos),
    .tw_nsin_o (tw_nsin)
  );

  dftd_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (mac_ctrl),
    .smp_i      (smp_rd),
    .tw_cos_i   (tw_cos),
    .tw_nsin_i  (tw_nsin),
    .busy_o     (mac_busy),
    .res_real_o (res_real),
    .res_imag_o (res_imag)
  );

  // output word register
  always_comb begin
    bin_valid_d = bin_valid_q;
    if (out_load) begin
      bin_valid_d = 1'b1;
    end else if (bin_ready_i) begin
      bin_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_valid_q <= 1'b0;
    end else begin
      bin_valid_q <= bin_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      bin_real_q <= res_real;
      bin_imag_q <= res_imag;
      bin_num_q  <= IDX_W'(k_q);
      final_q    <= last_k;
    end
  end

  assign bin_valid_o  = bin_valid_q;
  assign bin_real_o   = bin_real_q;
  assign bin_imag_o   = bin_imag_q;
  assign bin_number_o = bin_num_q;
  assign final_bin_o  = final_q;

  a_final_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_valid_o && final_bin_o |-> bin_number_o == IDX_W'(POINTS - 1))
    else $error("final bin flagged on wrong index");

  a_busy_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_busy |-> state_q == ST_MAC || state_q == ST_DRAIN)
    else $error("MAC busy outside compute");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !mac_busy && !bin_valid_q || state_q == ST_LOAD)
    else $error("sample taken while MAC active");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> bin_valid_o && bin_number_o == IDX_W'($past(k_q)))
    else $error("bin word not presented after load");

endmodule

// ----- bench/tb_direct_dft_engine_unit.sv -----
`timescale 1ns / 100ps

module tb_direct_dft_engine_unit;
  import dftd_pkg::*;

  localparam int NPTS = POINTS_DEF;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    PAT_ZERO,
    PAT_IMPULSE,
    PAT_DC,
    PAT_ALTERNATE
  } frame_pattern_e;

  typedef struct packed {
    frame_pattern_e            pat;
    logic signed [SMP_W-1:0]   re;
    logic signed [SMP_W-1:0]   im;
    logic [IDX_W-1:0]          pos;
    logic                      typed;
    logic signed [BIN_W-1:0]   t_re;
    logic signed [BIN_W-1:0]   t_im;
  } frame_row_t;

  typedef struct packed {
    logic signed [BIN_W-1:0] re;
    logic signed [BIN_W-1:0] im;
    logic [IDX_W-1:0]        k;
    logic                    last;
  } dft_bin_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic signed [SMP_W-1:0] in_real_i = '0;
  logic signed [SMP_W-1:0] in_imag_i = '0;
  logic                    bin_valid_o;
  logic                    bin_ready_i = 1'b0;
  logic signed [BIN_W-1:0] bin_real_o;
  logic signed [BIN_W-1:0] bin_imag_o;
  logic [IDX_W-1:0]        bin_number_o;
  logic                    final_bin_o;

  // directed frames; where typed is set, every bin of the frame carries t_re / t_im
  frame_row_t dir_frames [0:4] = '{
    '{PAT_ZERO,      16'sh0000, 16'sh0000, 6'd0,  1'b1, 23'sd0,     23'sd0},
    '{PAT_IMPULSE,   16'sh4000, 16'sh0000, 6'd0,  1'b1, 23'sd16384, 23'sd0},
    '{PAT_DC,        16'sh8000, 16'sh8000, 6'd0,  1'b0, 23'sd0,     23'sd0},
    '{PAT_ALTERNATE, 16'sh7FFF, 16'sh8000, 6'd0,  1'b0, 23'sd0,     23'sd0},
    '{PAT_IMPULSE,   16'sh8000, 16'sh7FFF, 6'd63, 1'b0, 23'sd0,     23'sd0}
  };

  int                      tw_cos  [NPTS];
  int                      tw_nsin [NPTS];
  logic signed [SMP_W-1:0] frame_re [NPTS];
  logic signed [SMP_W-1:0] frame_im [NPTS];
  int                      fill;
  logic                    typed_on;
  logic signed [BIN_W-1:0] typed_re;
  logic signed [BIN_W-1:0] typed_im;
  dft_bin_t                bins_due [$];
  int                      errors;
  logic                    calm;

  direct_dft_engine_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_real_i    (in_real_i),
    .in_imag_i    (in_imag_i),
    .bin_valid_o  (bin_valid_o),
    .bin_ready_i  (bin_ready_i),
    .bin_real_o   (bin_real_o),
    .bin_imag_o   (bin_imag_o),
    .bin_number_o (bin_number_o),
    .final_bin_o  (final_bin_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int q30_to_q15(input longint v);
    longint r;
    if (v < 0) return 0;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return int'(r);
  endfunction

  // Maclaurin series per quadrant, eight correction terms each
  function automatic void build_twiddles();
    longint unsigned theta, ts, tc;
    longint          s, c;
    int              q, r, cq, sq, co, si;
    for (int m = 0; m < NPTS; m++) begin
      q     = (4 * m) / NPTS;
      r     = (4 * m) % NPTS;
      theta = (HALF_PI_Q30 * longint'(r)) / longint'(NPTS);
      ts    = theta;
      tc    = 64'd1 << 30;
      s     = longint'(theta);
      c     = longint'(64'd1 << 30);
      for (int i = 1; i <= 8; i++) begin
        ts = ((((ts * theta) >> 30) * theta) >> 30) / longint'((2 * i) * (2 * i + 1));
        tc = ((((tc * theta) >> 30) * theta) >> 30) / longint'((2 * i - 1) * (2 * i));
        if (i % 2 == 1) begin
          s -= longint'(ts);
          c -= longint'(tc);
        end else begin
          s += longint'(ts);
          c += longint'(tc);
        end
      end
      cq = q30_to_q15(c);
      sq = q30_to_q15(s);
      case (q)
        0: begin co = cq;  si = sq;  end
        1: begin co = -sq; si = cq;  end
        2: begin co = -cq; si = -sq; end
        default: begin co = sq; si = -cq; end
      endcase
      tw_cos[m]  = co;
      tw_nsin[m] = -si;
    end
  endfunction

  function automatic logic signed [BIN_W-1:0] round_bin(input longint acc);
    longint v;
    v = (acc + RND_HALF) >>> FRAC_W;
    if (v > OUT_MAX) v = OUT_MAX;
    if (v < OUT_MIN) v = OUT_MIN;
    return v[BIN_W-1:0];
  endfunction

  function automatic void transform_frame();
    longint   ar, ai, xr, xi, wr, wi;
    int       m;
    dft_bin_t b;
    for (int k = 0; k < NPTS; k++) begin
      ar = 0;
      ai = 0;
      for (int n = 0; n < NPTS; n++) begin
        m  = (k * n) % NPTS;
        xr = longint'(frame_re[n]);
        xi = longint'(frame_im[n]);
        wr = longint'(tw_cos[m]);
        wi = longint'(tw_nsin[m]);
        ar += xr * wr - xi * wi;
        ai += xr * wi + xi * wr;
      end
      b.re   = typed_on ? typed_re : round_bin(ar);
      b.im   = typed_on ? typed_im : round_bin(ai);
      b.k    = k[IDX_W-1:0];
      b.last = (k == NPTS - 1);
      bins_due.push_back(b);
    end
  endfunction

  function automatic void store_sample(input logic signed [SMP_W-1:0] re,
                                       input logic signed [SMP_W-1:0] im);
    frame_re[fill] = re;
    frame_im[fill] = im;
    fill++;
    if (fill == NPTS) begin
      fill = 0;
      transform_frame();
    end
  endfunction

  function automatic void check_bin();
    dft_bin_t want;
    if (bins_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected bin word: k=%0d re=%0d im=%0d last=%0b",
                 bin_number_o, bin_real_o, bin_imag_o, final_bin_o);
    end else begin
      want = bins_due.pop_front();
      if (bin_real_o !== want.re || bin_imag_o !== want.im ||
          bin_number_o !== want.k || final_bin_o !== want.last) begin
        errors++;
        if (errors <= 10)
          $display({"bin mismatch: want k=%0d re=%0d im=%0d last=%0b, ",
                    "got k=%0d re=%0d im=%0d last=%0b"},
                   want.k, want.re, want.im, want.last,
                   bin_number_o, bin_real_o, bin_imag_o, final_bin_o);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (bin_valid_o && bin_ready_i) check_bin();
      bin_ready_i <= calm || ($urandom_range(0, 99) >= 21);
    end
  end

  task automatic send_sample(input logic signed [SMP_W-1:0] re,
                             input logic signed [SMP_W-1:0] im);
    while (!calm && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_real_i  <= re;
    in_imag_i  <= im;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    store_sample(re, im);
  endtask

  // drop valid in the step of the last acceptance, then let the bins drain
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [SMP_W-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  initial begin
    frame_row_t              row;
    logic signed [SMP_W-1:0] re, im;
    int                      mode;

    errors   = 0;
    fill     = 0;
    typed_on = 1'b0;
    typed_re = '0;
    typed_im = '0;
    calm     = 1'b0;
    build_twiddles();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_frames[f]) begin
      row      = dir_frames[f];
      typed_on = row.typed;
      typed_re = row.t_re;
      typed_im = row.t_im;
      for (int n = 0; n < NPTS; n++) begin
        case (row.pat)
          PAT_ZERO:    begin re = '0; im = '0; end
          PAT_IMPULSE: begin
            re = (n == row.pos) ? row.re : '0;
            im = (n == row.pos) ? row.im : '0;
          end
          PAT_DC:      begin re = row.re; im = row.im; end
          default:     begin
            re = (n % 2 == 0) ? row.re : ~row.re;
            im = (n % 2 == 0) ? row.im : ~row.im;
          end
        endcase
        send_sample(re, im);
      end
      typed_on = 1'b0;
    end
    wait_drained();

    // random frame; its second half and all of its bins run without idling
    mode = $urandom_range(0, 3);
    for (int n = 0; n < NPTS; n++) begin
      calm = (n >= NPTS / 2);
      case (mode)
        0: begin re = 16'($urandom); im = 16'($urandom); end
        1: begin
          re = 16'($urandom_range(0, 511)) - 16'd256;
          im = 16'($urandom_range(0, 511)) - 16'd256;
        end
        2: begin re = pick_extreme(); im = pick_extreme(); end
        default: begin
          re = $urandom_range(0, 1) ? pick_extreme() : 16'($urandom);
          im = $urandom_range(0, 1) ? pick_extreme() : 16'($urandom);
        end
      endcase
      send_sample(re, im);
    end
    wait_drained();
    calm = 1'b0;

    repeat (NPTS + 8) @(posedge clk_i);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
